// ----- rtl/core/kpt_pkg.sv -----
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared types and constants for the keyed pair table: the command and result
// words, the operation and status codes, and the word that travels the cells.
// ----------------------------------------------------------------------------
package kpt_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int OP_W          = 3;
    localparam int KEY_W         = 20;
    localparam int TAG_W         = 64;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] group_key;
        logic [KEY_W-1:0] member_key;
        logic [TAG_W-1:0] tag_value;
    } t_cmd_word;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] tag_out;
        logic [KEY_W-1:0] member_out;
    } t_result_word;

    // The command as it moves along the cells. A get overwrites tag with the
    // matched tag and a find overwrites member with the matched member.
    typedef struct packed {
        logic             valid;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] group;
        logic [KEY_W-1:0] member;
        logic [TAG_W-1:0] tag;
        logic             hit;
        logic             free_seen;
        logic [IDX_W-1:0] free_idx;
    } t_carry;

    // Write of a new pair into the first free cell once an add has passed.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] group;
        logic [KEY_W-1:0] member;
        logic [TAG_W-1:0] tag;
    } t_commit;

endpackage

// ----- rtl/core/kpt_cell.sv -----
// ----------------------------------------------------------------------------
// kpt_cell
// One table slot. Compares the passing command against its entry, acts on the
// first match (a close clears every entry of its member), and registers the command for the next cell.
// ----------------------------------------------------------------------------
module kpt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [kpt_pkg::IDX_W-1:0] i_index,
    input  kpt_pkg::t_carry           i_carry,
    input  kpt_pkg::t_commit          i_commit,
    output kpt_pkg::t_carry           o_carry
);

    logic                      r_valid;
    logic [kpt_pkg::KEY_W-1:0] r_group;
    logic [kpt_pkg::KEY_W-1:0] r_member;
    logic [kpt_pkg::TAG_W-1:0] r_tag;
    kpt_pkg::t_carry           r_carry;

    logic                      n_valid;
    logic [kpt_pkg::TAG_W-1:0] n_tag;
    kpt_pkg::t_carry           n_carry;

    logic pair_match;
    logic find_match;
    logic commit_here;

    assign pair_match  = r_valid && (r_group == i_carry.group)
                         && (r_member == i_carry.member);
    assign find_match  = r_valid && (r_group == i_carry.group) && (r_tag == i_carry.tag);
    assign commit_here = i_commit.en && (i_commit.idx == i_index);

    always_comb begin
        n_carry = i_carry;
        n_valid = r_valid;
        n_tag   = r_tag;
        if (i_carry.valid) begin
            unique case (i_carry.op)
                kpt_pkg::OP_ADD: begin
                    if (pair_match) begin
                        n_carry.hit = 1'b1;
                    end
                    if (!r_valid && !i_carry.free_seen) begin
                        n_carry.free_seen = 1'b1;
                        n_carry.free_idx  = i_index;
                    end
                end
                kpt_pkg::OP_MODIFY: begin
                    if (pair_match && !i_carry.hit) begin
                        n_carry.hit = 1'b1;
                        n_tag       = i_carry.tag;
                    end
                end
                kpt_pkg::OP_REMOVE: begin
                    if (pair_match && !i_carry.hit) begin
                        n_carry.hit = 1'b1;
                        n_valid     = 1'b0;
                    end
                end
                kpt_pkg::OP_GET: begin
                    if (pair_match && !i_carry.hit) begin
                        n_carry.hit = 1'b1;
                        n_carry.tag = r_tag;
                    end
                end
                kpt_pkg::OP_FIND: begin
                    if (find_match && !i_carry.hit) begin
                        n_carry.hit    = 1'b1;
                        n_carry.member = r_member;
                    end
                end
                kpt_pkg::OP_CLOSE: begin
                    if (r_valid && (r_member == i_carry.member)) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_carry.valid <= 1'b0;
        end else begin
            // A commit never meets a passing command: only one word is in flight.
            if (commit_here) begin
                r_valid <= 1'b1;
            end else begin
                r_valid <= n_valid;
            end
            r_carry <= n_carry;
        end
        if (commit_here) begin
            r_group  <= i_commit.group;
            r_member <= i_commit.member;
            r_tag    <= i_commit.tag;
        end else begin
            r_tag <= n_tag;
        end
    end

    assign o_carry = r_carry;

endmodule

// ----- rtl/core/keyed_pair_table_top.sv -----
// ----------------------------------------------------------------------------
// keyed_pair_table_top
// Keyed pair table: add, modify, remove, get, find member and close member on
// a fixed row of pair-key/tag slots, one result word per command word.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. It walks the
// row of TABLE_ENTRIES slot cells one cell per cycle; after the last cell the
// result word is registered and appears on o_result, marked by o_result_valid
// for one cycle. busy drops in that same cycle, so the block takes no new
// command until the result word of the one before it is shown.
// The result must be captured in its strobe cycle; o_result holds it only
// until the next result word. An add writes its slot at the end of the walk.
// The table is empty after reset.
// ----------------------------------------------------------------------------
module keyed_pair_table_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  kpt_pkg::t_cmd_word    i_cmd,
    output logic                  o_result_valid,
    output kpt_pkg::t_result_word o_result
);

    kpt_pkg::t_carry      w_carry [0:kpt_pkg::TABLE_ENTRIES];
    kpt_pkg::t_carry      w_tail;
    kpt_pkg::t_commit     w_commit;
    kpt_pkg::t_result_word n_result;

    logic                  r_busy;
    logic                  r_result_valid;
    kpt_pkg::t_result_word r_result;
    logic                  accept;

    assign accept = start && !r_busy;

    always_comb begin
        w_carry[0].valid     = accept;
        w_carry[0].op        = i_cmd.operation;
        w_carry[0].group     = i_cmd.group_key;
        w_carry[0].member    = i_cmd.member_key;
        w_carry[0].tag       = i_cmd.tag_value;
        w_carry[0].hit       = 1'b0;
        w_carry[0].free_seen = 1'b0;
        w_carry[0].free_idx  = '0;
    end

    for (genvar i = 0; i < kpt_pkg::TABLE_ENTRIES; i++) begin : g_cell
        kpt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (kpt_pkg::IDX_W'(i)),
            .i_carry  (w_carry[i]),
            .i_commit (w_commit),
            .o_carry  (w_carry[i+1])
        );
    end

    assign w_tail = w_carry[kpt_pkg::TABLE_ENTRIES];

    always_comb begin
        w_commit.en     = w_tail.valid && (w_tail.op == kpt_pkg::OP_ADD)
                          && !w_tail.hit && w_tail.free_seen;
        w_commit.idx    = w_tail.free_idx;
        w_commit.group  = w_tail.group;
        w_commit.member = w_tail.member;
        w_commit.tag    = w_tail.tag;
    end

    always_comb begin
        n_result.status     = kpt_pkg::ST_OK;
        n_result.tag_out    = '0;
        n_result.member_out = '0;
        unique case (w_tail.op)
            kpt_pkg::OP_ADD: begin
                if (w_tail.hit) begin
                    n_result.status = kpt_pkg::ST_DUPLICATE;
                end else if (!w_tail.free_seen) begin
                    n_result.status = kpt_pkg::ST_FULL;
                end
            end
            kpt_pkg::OP_MODIFY, kpt_pkg::OP_REMOVE: begin
                if (!w_tail.hit) begin
                    n_result.status = kpt_pkg::ST_NOT_FOUND;
                end
            end
            kpt_pkg::OP_GET: begin
                if (w_tail.hit) begin
                    n_result.tag_out = w_tail.tag;
                end else begin
                    n_result.status = kpt_pkg::ST_NOT_FOUND;
                end
            end
            kpt_pkg::OP_FIND: begin
                if (w_tail.hit) begin
                    n_result.member_out = w_tail.member;
                end else begin
                    n_result.status = kpt_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            r_result_valid <= w_tail.valid;
        end
        if (w_tail.valid) begin
            r_result <= n_result;
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ----- rtl/core/kpt_checker.sv -----
// ----------------------------------------------------------------------------
// kpt_checker
// Port-level checks on the keyed pair table, bound to the top level.
// ----------------------------------------------------------------------------
module kpt_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_result_valid,
    input kpt_pkg::t_result_word o_result
);

    // A taken command word keeps the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command word was taken");

    // The block becomes free exactly when it shows its result word.
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result word");

    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result word shown while still busy");

    // One result word per command: the strobe is never held high back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A failed operation returns no tag and no member.
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != kpt_pkg::ST_OK))
        |-> ((o_result.tag_out == '0) && (o_result.member_out == '0)))
        else $error("nonzero tag or member with a failing status");

endmodule

bind keyed_pair_table_top kpt_checker u_kpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
